>>> sv/mse_pkg.sv
package mse_pkg;

    localparam int DATA_WORDS = 1024;
    localparam int DATA_AW    = $clog2(DATA_WORDS);

    localparam logic [5:0] OP_RTYPE   = 6'h00;
    localparam logic [5:0] OP_J       = 6'h02;
    localparam logic [5:0] OP_JAL     = 6'h03;
    localparam logic [5:0] OP_BEQ     = 6'h04;
    localparam logic [5:0] OP_BNE     = 6'h05;
    localparam logic [5:0] OP_BLEZ    = 6'h06;
    localparam logic [5:0] OP_ADDIMM  = 6'h09;
    localparam logic [5:0] OP_SLTI    = 6'h0A;
    localparam logic [5:0] OP_SLTIMMU = 6'h0B;
    localparam logic [5:0] OP_ORI     = 6'h0D;
    localparam logic [5:0] OP_LUI     = 6'h0F;
    localparam logic [5:0] OP_LB      = 6'h20;
    localparam logic [5:0] OP_LW      = 6'h23;
    localparam logic [5:0] OP_LBU     = 6'h24;
    localparam logic [5:0] OP_SB      = 6'h28;
    localparam logic [5:0] OP_SW      = 6'h2B;

    localparam logic [5:0] FN_SLL  = 6'h00;
    localparam logic [5:0] FN_SRL  = 6'h02;
    localparam logic [5:0] FN_SRA  = 6'h03;
    localparam logic [5:0] FN_JR   = 6'h08;
    localparam logic [5:0] FN_JALR = 6'h09;
    localparam logic [5:0] FN_ADD  = 6'h20;
    localparam logic [5:0] FN_ADDU = 6'h21;
    localparam logic [5:0] FN_SUB  = 6'h22;
    localparam logic [5:0] FN_SUBU = 6'h23;
    localparam logic [5:0] FN_AND  = 6'h24;
    localparam logic [5:0] FN_OR   = 6'h25;
    localparam logic [5:0] FN_XOR  = 6'h26;
    localparam logic [5:0] FN_NOR  = 6'h27;
    localparam logic [5:0] FN_SLT  = 6'h2A;

    localparam logic [31:0] SEG_MASK = 32'hF000_0000;

    // classified instruction handed from front to back
    typedef struct packed {
        logic [31:0] insn;
        logic        bad;
    } dec_t;

    function automatic logic insn_bad(input logic [31:0] insn);
        logic [5:0] op;
        logic [5:0] fn;
        logic       r;
        op = insn[31:26];
        fn = insn[5:0];
        r  = 1'b0;
        unique case (op)
            OP_RTYPE:
            begin
                unique case (fn)
                    FN_SLL, FN_SRL, FN_SRA, FN_JR, FN_JALR, FN_ADD, FN_ADDU,
                    FN_SUB, FN_SUBU, FN_AND, FN_OR, FN_XOR, FN_NOR, FN_SLT: r = 1'b0;
                    default: r = 1'b1;
                endcase
            end
            OP_J, OP_JAL, OP_BEQ, OP_BNE, OP_BLEZ, OP_ADDIMM, OP_SLTI, OP_SLTIMMU,
            OP_ORI, OP_LUI, OP_LB, OP_LW, OP_LBU, OP_SB, OP_SW: r = 1'b0;
            default: r = 1'b1;
        endcase
        return r;
    endfunction

endpackage

>>> sv/mips_subset_execute_unit.sv
// MIPS32 integer subset execute unit with one branch delay slot. Feed it the
// instruction word fetched at the next_address of the previous result (at
// start_address after a start_address write, at 0 after reset). A front queue
// of two entries accepts and classifies instructions; the back end reads the
// register file and the synchronous data memory at issue and commits in a
// finish phase that waits on the output register, a split set by the
// registered memory read. Results sit in an output register while the next
// transaction is accepted. Data memory contents are undefined until written.
module mips_subset_execute_unit (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [31:0] start_address,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [31:0] instruction,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [31:0] executed_address,
    output logic [31:0] next_address,
    output logic        write_enable,
    output logic [4:0]  write_register,
    output logic [31:0] write_value,
    output logic        store_enable,
    output logic [31:0] store_address,
    output logic        fault
);

    logic          q_valid, q_ready, cfg_we;
    mse_pkg::dec_t q_data;

    // configuration must only arrive while idle; the block does not enforce it
    assign cfg_ready = 1'b1;
    assign cfg_we    = cfg_valid;

    mse_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .flush    (cfg_we),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .in_insn  (instruction),
        .q_valid  (q_valid),
        .q_ready  (q_ready),
        .q_data   (q_data)
    );

    mse_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_data  (start_address),
        .q_valid   (q_valid),
        .q_ready   (q_ready),
        .q_data    (q_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .o_exec    (executed_address),
        .o_next    (next_address),
        .o_wen     (write_enable),
        .o_wreg    (write_register),
        .o_wval    (write_value),
        .o_sen     (store_enable),
        .o_saddr   (store_address),
        .o_fault   (fault)
    );

endmodule

>>> sv/mse_ram.sv
module mse_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

>>> sv/mse_front.sv
module mse_front (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            flush,
    input  logic            in_valid,
    output logic            in_ready,
    input  logic [31:0]     in_insn,
    output logic            q_valid,
    input  logic            q_ready,
    output mse_pkg::dec_t   q_data
);

    // two-entry queue with classification at entry
    mse_pkg::dec_t ent_reg [2];
    logic [1:0]    cnt_reg, cnt_next;
    logic          rd_reg, rd_next;
    logic          push, pop;

    assign in_ready = (cnt_reg != 2'd2);
    assign push     = in_valid && in_ready;
    assign q_valid  = (cnt_reg != 2'd0);
    assign pop      = q_valid && q_ready;
    assign q_data   = ent_reg[rd_reg];

    always_comb
    begin
        cnt_next = cnt_reg + {1'b0, push} - {1'b0, pop};
        rd_next  = rd_reg ^ pop;
        if (flush)
        begin
            cnt_next = 2'd0;
            rd_next  = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= 2'd0;
            rd_reg  <= 1'b0;
        end
        else
        begin
            cnt_reg <= cnt_next;
            rd_reg  <= rd_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            ent_reg[rd_reg ^ cnt_reg[0]] <= '{insn: in_insn, bad: mse_pkg::insn_bad(in_insn)};
        end
    end

`ifndef ASSERT_OFF
    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg == 2'd2 |-> !in_ready) else $error("queue overflow");
    a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg != 2'd3) else $error("queue count out of range");
    a_empty_idle: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg == 2'd0 |-> !q_valid) else $error("empty queue presents data");
`endif

endmodule

>>> sv/mse_back.sv
module mse_back (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            cfg_we,
    input  logic [31:0]     cfg_data,
    input  logic            q_valid,
    output logic            q_ready,
    input  mse_pkg::dec_t   q_data,
    output logic            out_valid,
    input  logic            out_ready,
    output logic [31:0]     o_exec,
    output logic [31:0]     o_next,
    output logic            o_wen,
    output logic [4:0]      o_wreg,
    output logic [31:0]     o_wval,
    output logic            o_sen,
    output logic [31:0]     o_saddr,
    output logic            o_fault
);

    // two phases: issue reads regfile and ram; finish commits
    logic [31:0] rf_reg [32];
    logic [31:0] pc_reg, pc_next;
    logic        dp_reg, dp_next;
    logic [31:0] dt_reg, dt_next;
    logic        busy_reg, busy_next;
    logic [31:0] ins_reg, a_reg, b_reg, addr_reg;
    logic        bad_reg;
    logic        ov_reg;

    logic [31:0] ri_simm, ri_addr;
    logic [mse_pkg::DATA_AW-1:0] ram_raddr, ram_waddr;
    logic [31:0] ram_rdata, ram_wdata;
    logic        ram_we;

    assign ri_simm   = {{16{q_data.insn[15]}}, q_data.insn[15:0]};
    assign ri_addr   = rf_reg[q_data.insn[25:21]] + ri_simm;
    // keep reading the issued word while the finish waits on the output
    assign ram_raddr = busy_reg ? addr_reg[mse_pkg::DATA_AW+1:2]
                                : ri_addr[mse_pkg::DATA_AW+1:2];

    logic can_out;
    assign can_out  = !ov_reg || out_ready;
    assign q_ready  = !busy_reg;
    assign out_valid = ov_reg;

    // finish stage decode
    logic [5:0]  op, fn;
    logic [4:0]  sa;
    logic [31:0] simm, slot, tgt, wval, bytev, nxt;
    logic        wen, sen, jmp;
    logic [4:0]  wreg;
    logic [4:0]  lane;

    always_comb
    begin
        op    = ins_reg[31:26];
        fn    = ins_reg[5:0];
        sa    = ins_reg[10:6];
        simm  = {{16{ins_reg[15]}}, ins_reg[15:0]};
        slot  = pc_reg + 32'd4;
        lane  = {~addr_reg[1:0], 3'b000};
        bytev = {24'd0, 8'(ram_rdata >> lane)};
        wen = 1'b0; sen = 1'b0; jmp = 1'b0;
        wreg = ins_reg[20:16]; wval = 32'd0; tgt = 32'd0;
        ram_wdata = b_reg;
        unique case (op)
            mse_pkg::OP_RTYPE:
            begin
                wen = 1'b1; wreg = ins_reg[15:11];
                unique case (fn)
                    mse_pkg::FN_SLL: wval = b_reg << sa;
                    mse_pkg::FN_SRL: wval = b_reg >> sa;
                    mse_pkg::FN_SRA: wval = 32'($signed(b_reg) >>> sa);
                    mse_pkg::FN_JR:
                    begin
                        wen = 1'b0; jmp = 1'b1; tgt = a_reg;
                    end
                    mse_pkg::FN_JALR:
                    begin
                        wval = pc_reg + 32'd8; jmp = 1'b1; tgt = a_reg;
                    end
                    mse_pkg::FN_ADD, mse_pkg::FN_ADDU: wval = a_reg + b_reg;
                    mse_pkg::FN_SUB, mse_pkg::FN_SUBU: wval = a_reg - b_reg;
                    mse_pkg::FN_AND: wval = a_reg & b_reg;
                    mse_pkg::FN_OR:  wval = a_reg | b_reg;
                    mse_pkg::FN_XOR: wval = a_reg ^ b_reg;
                    mse_pkg::FN_NOR: wval = ~(a_reg | b_reg);
                    mse_pkg::FN_SLT: wval = {31'd0, $signed(a_reg) < $signed(b_reg)};
                    default: wen = 1'b0;
                endcase
            end
            mse_pkg::OP_J, mse_pkg::OP_JAL:
            begin
                jmp = 1'b1;
                tgt = (slot & mse_pkg::SEG_MASK) | {4'd0, ins_reg[25:0], 2'b00};
                if (op == mse_pkg::OP_JAL)
                begin
                    wen = 1'b1; wreg = 5'd31; wval = pc_reg + 32'd8;
                end
            end
            mse_pkg::OP_BEQ, mse_pkg::OP_BNE, mse_pkg::OP_BLEZ:
            begin
                tgt = slot + {simm[29:0], 2'b00};
                priority if (op == mse_pkg::OP_BEQ) jmp = (a_reg == b_reg);
                else if (op == mse_pkg::OP_BNE) jmp = (a_reg != b_reg);
                else jmp = (a_reg == 32'd0) || a_reg[31];
            end
            mse_pkg::OP_ADDIMM: begin wen = 1'b1; wval = a_reg + simm; end
            mse_pkg::OP_SLTI:
            begin
                wen = 1'b1; wval = {31'd0, $signed(a_reg) < $signed(simm)};
            end
            mse_pkg::OP_SLTIMMU: begin wen = 1'b1; wval = {31'd0, a_reg < simm}; end
            mse_pkg::OP_ORI:  begin wen = 1'b1; wval = a_reg | {16'd0, ins_reg[15:0]}; end
            mse_pkg::OP_LUI:  begin wen = 1'b1; wval = {ins_reg[15:0], 16'd0}; end
            mse_pkg::OP_LB:   begin wen = 1'b1; wval = {{24{bytev[7]}}, bytev[7:0]}; end
            mse_pkg::OP_LBU:  begin wen = 1'b1; wval = bytev; end
            mse_pkg::OP_LW:   begin wen = 1'b1; wval = ram_rdata; end
            mse_pkg::OP_SB:
            begin
                sen = 1'b1;
                ram_wdata = (ram_rdata & ~(32'hFF << lane)) | ({24'd0, b_reg[7:0]} << lane);
            end
            mse_pkg::OP_SW: sen = 1'b1;
            default: wen = 1'b0;
        endcase
        if (bad_reg)
        begin
            wen = 1'b0; sen = 1'b0; jmp = 1'b0;
        end
        if (wreg == 5'd0)
        begin
            wen = 1'b0;
        end
        nxt = bad_reg ? pc_reg : (dp_reg ? dt_reg : slot);
    end

    logic fin;
    assign fin       = busy_reg && can_out;
    assign ram_we    = fin && sen;
    assign ram_waddr = addr_reg[mse_pkg::DATA_AW+1:2];

    mse_ram #(.WIDTH(32), .DEPTH(mse_pkg::DATA_WORDS)) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    always_comb
    begin
        busy_next = busy_reg;
        pc_next   = pc_reg;
        dp_next   = dp_reg;
        dt_next   = dt_reg;
        priority if (cfg_we)
        begin
            pc_next = cfg_data; dp_next = 1'b0;
        end
        else if (fin)
        begin
            busy_next = 1'b0;
            if (!bad_reg)
            begin
                pc_next = nxt;
                dp_next = jmp;
                if (jmp) dt_next = tgt;
            end
        end
        else if (q_valid && q_ready)
        begin
            busy_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            pc_reg   <= 32'd0;
            dp_reg   <= 1'b0;
            dt_reg   <= 32'd0;
            ov_reg   <= 1'b0;
            for (int i = 0; i < 32; i++) rf_reg[i] <= 32'd0;
        end
        else
        begin
            busy_reg <= busy_next;
            pc_reg   <= pc_next;
            dp_reg   <= dp_next;
            dt_reg   <= dt_next;
            if (fin) ov_reg <= 1'b1;
            else if (out_ready) ov_reg <= 1'b0;
            if (fin && wen) rf_reg[wreg] <= wval;
        end
    end

    always_ff @(posedge clk)
    begin
        if (q_valid && q_ready)
        begin
            ins_reg  <= q_data.insn;
            bad_reg  <= q_data.bad;
            a_reg    <= rf_reg[q_data.insn[25:21]];
            b_reg    <= rf_reg[q_data.insn[20:16]];
            addr_reg <= ri_addr;
        end
        if (fin)
        begin
            o_exec  <= pc_reg;
            o_next  <= nxt;
            o_wen   <= wen;
            o_wreg  <= wen ? wreg : 5'd0;
            o_wval  <= wen ? wval : 32'd0;
            o_sen   <= sen;
            o_saddr <= sen ? addr_reg : 32'd0;
            o_fault <= bad_reg;
        end
    end

`ifndef ASSERT_OFF
    a_r0_zero: assert property (@(posedge clk) disable iff (!rst_n)
        rf_reg[0] == 32'd0) else $error("r0 written");
    a_fault_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        fin && bad_reg |=> o_fault && !o_wen && !o_sen) else $error("fault side effect");
    a_fault_pc: assert property (@(posedge clk) disable iff (!rst_n)
        fin && bad_reg && !cfg_we |=> pc_reg == $past(pc_reg)) else $error("fault moved pc");
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        ov_reg && !out_ready |=> ov_reg && $stable(o_exec)) else $error("result lost");
`endif

endmodule
